// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// clocked checks with reset disable, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// expression must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// property with implication, checked on every clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`endif
`endif

// File: src/usv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_pkg: shared types and codes for the unique value set store
// beat layouts, operation and status codes, cell command struct
// ----------------------------------------------------------------------------
package usv_pkg;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } usv_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
  } usv_out_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic add_en;
    logic rem_en;
  } usv_cmd_t;

endpackage

// File: src/usv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_cell: one entry of the set store
// holds an entry, matches the broadcast value, takes its upper neighbour on
// remove and passes match and read data along the chain
// ----------------------------------------------------------------------------
module usv_cell #(
  parameter int CAPACITY    = usv_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = usv_pkg::DEF_VALUE_WIDTH,
  parameter int IDX         = 0
) (
  input  logic                              clk,
  input  usv_pkg::usv_cmd_t                 cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]     count_i,
  input  logic [usv_pkg::POS_W-1:0]         pos_i,
  input  logic [VALUE_WIDTH-1:0]            value_i,
  input  logic [VALUE_WIDTH-1:0]            next_i,
  input  logic                              hit_i,
  input  logic [VALUE_WIDTH-1:0]            rd_i,
  output logic [VALUE_WIDTH-1:0]            entry_o,
  output logic                              hit_o,
  output logic [VALUE_WIDTH-1:0]            rd_o
);
  import usv_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [VALUE_WIDTH-1:0] entry_r;
  logic [VALUE_WIDTH-1:0] entry_nxt;
  logic                   occupied;
  logic                   at_tail;
  logic                   at_pos;
  logic                   above_pos;

  assign occupied  = MY_IDX < count_i;
  assign at_tail   = MY_IDX == count_i;
  assign at_pos    = PW'(MY_IDX) == PW'(pos_i);
  assign above_pos = PW'(MY_IDX) >= PW'(pos_i);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.add_en && at_tail) begin
      entry_nxt = value_i;
    end else if (cmd.rem_en && above_pos) begin
      entry_nxt = next_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign hit_o   = hit_i | (occupied && (entry_r == value_i));
  assign rd_o    = rd_i | (at_pos ? entry_r : '0);

endmodule

// File: src/unique_value_set_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_set_store: ordered set of distinct values
// chain of entry cells with broadcast match, shift-down remove and read select
// ----------------------------------------------------------------------------
// result beat is registered in the cycle after the input beat is taken
// throughput: one item per cycle while the result side keeps up
// the duplicate match and the read select ripple through all CAPACITY cells
// reset: entry count cleared, output emptied; entries hold until written
`include "assert_macros.svh"

module unique_value_set_store #(
  parameter int CAPACITY    = usv_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = usv_pkg::DEF_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  usv_pkg::usv_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output usv_pkg::usv_out_t out_data
);
  import usv_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = (CW > POS_W) ? CW : POS_W;
  localparam int IN_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  usv_out_t               out_data_r;
  usv_out_t               out_data_nxt;

  logic                   in_fire;
  logic [VALUE_WIDTH-1:0] value_w;
  logic                   hit;
  logic                   pos_ok;
  logic                   full;
  logic [STATUS_W-1:0]    status;
  logic [DATA_W-1:0]      rd_word;
  usv_cmd_t               cmd;

  logic [VALUE_WIDTH-1:0] entry_w [CAPACITY];
  logic [VALUE_WIDTH-1:0] next_w  [CAPACITY];
  logic                   hit_c   [CAPACITY+1];
  logic [VALUE_WIDTH-1:0] rd_c    [CAPACITY+1];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign value_w = VALUE_WIDTH'(in_data.value[IN_W-1:0]);

  assign hit_c[0] = 1'b0;
  assign rd_c[0]  = '0;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi < CAPACITY - 1) begin : g_mid
        assign next_w[gi] = entry_w[gi+1];
      end else begin : g_last
        assign next_w[gi] = '0;
      end

      usv_cell #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX         (gi)
      ) u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .count_i (count_r),
        .pos_i   (in_data.position),
        .value_i (value_w),
        .next_i  (next_w[gi]),
        .hit_i   (hit_c[gi]),
        .rd_i    (rd_c[gi]),
        .entry_o (entry_w[gi]),
        .hit_o   (hit_c[gi+1]),
        .rd_o    (rd_c[gi+1])
      );
    end
  endgenerate

  assign hit     = hit_c[CAPACITY];
  assign pos_ok  = PW'(in_data.position) < PW'(count_r);
  assign full    = count_r == FULL_COUNT;
  assign rd_word = DATA_W'(rd_c[CAPACITY][IN_W-1:0]);

  always_comb begin
    status     = ST_DONE;
    cmd.add_en = 1'b0;
    cmd.rem_en = 1'b0;
    case (in_data.operation)
      OP_ADD: begin
        if (hit) begin
          status = ST_DUPLICATE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cmd.add_en = in_fire;
        end
      end
      OP_REMOVE: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          cmd.rem_en = in_fire;
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.add_en) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rem_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.status     = status;
      out_data_nxt.read_value = (in_data.operation == OP_READ && pos_ok) ? rd_word : '0;
      out_data_nxt.count      = COUNT_W'(count_nxt);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= FULL_COUNT, "entry count above capacity")
  `ASSERT_PROP(a_add_grows, clk, rst_n, (cmd.add_en) |=> (count_r == $past(count_r) + CW'(1)), "stored add did not grow count")
  `ASSERT_PROP(a_full_only_full, clk, rst_n, (in_fire && status == ST_FULL) |-> (count_r == FULL_COUNT), "full reported below capacity")
  `ASSERT_PROP(a_one_cmd, clk, rst_n, (cmd.add_en || cmd.rem_en) |-> (in_fire && !(cmd.add_en && cmd.rem_en)), "cell command without a single accepted beat")
  `ASSERT_PROP(a_fire_gives_result, clk, rst_n, in_fire |=> out_valid_r, "accepted beat left no result")

endmodule

// File: bench/unique_value_set_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_set_store_tb: self-checking bench for the unique value set store
// drives add, remove and read beats with random gaps on both channels, keeps a
// shadow copy of the set and compares every result beat field by field
// ----------------------------------------------------------------------------
module unique_value_set_store_tb;
  import usv_pkg::*;

  localparam int               SET_DEPTH   = DEF_CAPACITY;
  localparam int               POOL_SIZE   = 24;
  localparam int               STALL_LIMIT = 2000;
  localparam int               RANDOM_BEATS = 900;
  localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;

  typedef enum int {GROW, SHRINK, MIXED} traffic_mode_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  usv_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  usv_out_t out_data;

  // shadow copy of the set
  logic [DATA_W-1:0] set_entries [SET_DEPTH];
  int                set_count;

  usv_out_t          expected_results [$];
  usv_out_t          want_result;
  logic [DATA_W-1:0] value_pool [POOL_SIZE];
  int                mismatch_count;
  int                result_index;
  int                idle_cycles;
  bit                no_idle;

  unique_value_set_store i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic usv_out_t predict_set_step(input usv_in_t item);
    usv_out_t res;
    bit       hit;
    int       pos;
    res        = '0;
    res.status = ST_DONE;
    hit        = 1'b0;
    pos        = int'(item.position);
    case (item.operation)
      OP_ADD: begin
        for (int i = 0; i < set_count; i++)
          if (set_entries[i] == item.value) hit = 1'b1;
        if (hit) begin
          res.status = ST_DUPLICATE;
        end else if (set_count >= SET_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          set_entries[set_count] = item.value;
          set_count++;
        end
      end
      OP_REMOVE: begin
        if (pos >= set_count) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < set_count; i++) set_entries[i] = set_entries[i+1];
          set_count--;
        end
      end
      OP_READ: begin
        if (pos >= set_count) res.status = ST_RANGE;
        else res.read_value = set_entries[pos];
      end
      default: ;
    endcase
    res.count = set_count[COUNT_W-1:0];
    return res;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic usv_in_t make_item(input logic [OP_W-1:0] op,
                                        input logic [DATA_W-1:0] value,
                                        input int pos);
    usv_in_t item;
    item.operation = op;
    item.value     = value;
    item.position  = pos[POS_W-1:0];
    return item;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", result_index, msg);
    mismatch_count++;
  endtask

  task automatic send_item(input usv_in_t item);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_set_step(item));
  endtask

  // drop valid and hold off until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_store();
    send_item(make_item(OP_READ, $urandom, 0));
    send_item(make_item(OP_REMOVE, $urandom, 0));
    send_item(make_item(OP_READ, $urandom, 15));
    send_item(make_item(OP_UNUSED, $urandom, $urandom_range(0, 15)));
  endtask

  task automatic test_value_extremes();
    send_item(make_item(OP_ADD, 32'h8000_0000, 0));
    send_item(make_item(OP_ADD, 32'h7fff_ffff, 15));
    send_item(make_item(OP_ADD, 32'h0000_0000, 0));
    send_item(make_item(OP_ADD, 32'hffff_ffff, 0));
    send_item(make_item(OP_ADD, 32'h8000_0000, 0));
    send_item(make_item(OP_READ, $urandom, 3));
  endtask

  task automatic test_full_store();
    while (set_count < SET_DEPTH)
      send_item(make_item(OP_ADD, 32'h1234_0000 + set_count, 0));
    // pause until the set is settled before probing the full case
    drain_results();
    send_item(make_item(OP_ADD, 32'h5a5a_a5a5, 0));
    send_item(make_item(OP_ADD, 32'h7fff_ffff, 0));
    send_item(make_item(OP_READ, 0, 15));
    send_item(make_item(OP_REMOVE, 0, 15));
    send_item(make_item(OP_REMOVE, 0, 0));
    send_item(make_item(OP_REMOVE, 0, 14));
    send_item(make_item(OP_UNUSED, 32'hffff_ffff, 15));
  endtask

  function automatic usv_in_t random_item(input traffic_mode_t mode);
    int                r;
    int                v;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    int                pos;
    r = $urandom_range(0, 99);
    if (r >= 98) op = OP_UNUSED;
    else if (mode == GROW) op = (r < 70) ? OP_ADD : (r < 85) ? OP_REMOVE : OP_READ;
    else if (mode == SHRINK) op = (r < 25) ? OP_ADD : (r < 70) ? OP_REMOVE : OP_READ;
    else op = (r < 40) ? OP_ADD : (r < 60) ? OP_REMOVE : OP_READ;
    v = $urandom_range(0, 99);
    if (v < 40) value = value_pool[$urandom_range(0, POOL_SIZE-1)];
    else if (v < 60 && set_count > 0) value = set_entries[$urandom_range(0, set_count-1)];
    else value = $urandom;
    // mostly positions near the live range, including one past the end
    if ($urandom_range(0, 99) < 80)
      pos = $urandom_range(0, (set_count > 15) ? 15 : set_count);
    else
      pos = $urandom_range(0, 15);
    return make_item(op, value, pos);
  endfunction

  task automatic test_random_traffic(input int n_items);
    int            sent;
    int            burst;
    traffic_mode_t mode;
    sent = 0;
    while (sent < n_items) begin
      mode    = traffic_mode_t'($urandom_range(0, 2));
      burst   = $urandom_range(10, 40);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        send_item(random_item(mode));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // result side: random back-pressure with steady stretches
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_gap()) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want_result = expected_results.pop_front();
        if (out_data.status !== want_result.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, want_result.status));
        if (out_data.read_value !== want_result.read_value)
          report_mismatch($sformatf("read_value got %h want %h",
                                    out_data.read_value, want_result.read_value));
        if (out_data.count !== want_result.count)
          report_mismatch($sformatf("count got %0d want %0d",
                                    out_data.count, want_result.count));
      end
      result_index++;
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: no beat for %0d cycles", idle_cycles);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    set_count      = 0;
    mismatch_count = 0;
    result_index   = 0;
    idle_cycles    = 0;
    no_idle        = 1'b0;
    for (int i = 0; i < SET_DEPTH; i++) set_entries[i] = '0;
    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_value_extremes();
    test_full_store();
    test_random_traffic(RANDOM_BEATS);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
